[design/svalloc_pkg.sv]
// ----------------------------------------------------------------------------
// svalloc_pkg
// Shared types and constants for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package svalloc_pkg;

    // Default number of voices
    localparam int VOICE_COUNT_DEF = 16;

    // MIDI status codes
    localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
    localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
    localparam logic [7:0] MIDI_BEND     = 8'hE0;

    // Stored note value of a voice that holds nothing
    localparam logic [7:0] NO_NOTE = 8'hFF;

    // Result action codes
    typedef logic [1:0] action_t;
    localparam action_t ACT_NONE    = 2'd0;
    localparam action_t ACT_TRIGGER = 2'd1;
    localparam action_t ACT_RELEASE = 2'd2;
    localparam action_t ACT_BEND    = 2'd3;

    // Envelope stage and frame count of one voice
    typedef struct packed {
        logic [2:0]  stage;
        logic [31:0] frames;
    } voice_env_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

[design/synth_voice_allocator_top.sv]
// ----------------------------------------------------------------------------
// synth_voice_allocator_top
// Polyphonic voice allocator with voice stealing over a scanned voice table.
// ----------------------------------------------------------------------------
// Usage: drive one item on the input ports with start high; it transfers at
// the rising edge where start is high and busy is low. op = 0 carries a
// three-byte MIDI message, op = 1 a voice status report from the envelope
// engine. Every item gives exactly one result, shown for one cycle with done
// high; the receiver cannot stall, so each result must be taken that cycle.
// Flow: status reports, pitch bend and unknown messages give their result
// in the cycle after the transfer and keep busy low, so they can follow each
// other every cycle. Note on and note off walk the voice table one voice per
// cycle through a single compare unit, and the result is registered once the
// walk ends; a note on that meets an idle voice stops early at that voice.
// busy stays high for the walk. The table sits in two memories with
// registered reads; per-voice valid bits give the reset values at once, so
// no clearing pass is needed and the block can take an item in the first
// cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module synth_voice_allocator_top #(
    parameter int VOICE_COUNT = svalloc_pkg::VOICE_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        op,
    input  wire logic [7:0]  status_byte,
    input  wire logic [6:0]  data_one,
    input  wire logic [6:0]  data_two,
    input  wire logic [3:0]  voice_index,
    input  wire logic [2:0]  env_stage,
    input  wire logic [31:0] env_frames,
    output logic             done,
    output logic [1:0]       action,
    output logic [3:0]       chosen_voice,
    output logic [6:0]       note,
    output logic [6:0]       velocity,
    output logic [15:0]      release_mask,
    output logic [13:0]      bend_value
);

    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CNT_W = $clog2(VOICE_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(VOICE_COUNT);

    // Sequencer
    svalloc_pkg::state_t state_reg, state_next;

    // Voice table memories and valid bits
    logic [7:0]              note_mem [VOICE_COUNT];
    svalloc_pkg::voice_env_t env_mem  [VOICE_COUNT];
    logic [VOICE_COUNT-1:0]  note_vld_reg;
    logic [VOICE_COUNT-1:0]  env_vld_reg;

    logic [7:0]              note_rd_reg;
    svalloc_pkg::voice_env_t env_rd_reg;
    logic                    note_rd_vld_reg;
    logic                    env_rd_vld_reg;

    // Write port
    logic                    note_we;
    logic                    env_we;
    logic [IDX_W-1:0]        wr_addr;
    logic [7:0]              note_wdata;
    svalloc_pkg::voice_env_t env_wdata;
    logic [IDX_W-1:0]        rd_addr;

    // Scan control
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic             eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;

    // Held item fields
    logic [6:0] d1_reg, d1_next;
    logic [6:0] d2_reg, d2_next;
    logic       on_reg, on_next;

    // Running victim and release mask
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [2:0]       best_stage_reg, best_stage_next;
    logic [31:0]      best_frames_reg, best_frames_next;
    logic [15:0]      mask_reg, mask_next;

    // Result registers
    logic                 done_reg, done_next;
    svalloc_pkg::action_t action_reg, action_next;
    logic [3:0]           chosen_reg, chosen_next;
    logic [6:0]           note_out_reg, note_out_next;
    logic [6:0]           vel_reg, vel_next;
    logic [15:0]          rmask_reg, rmask_next;
    logic [13:0]          bend_reg, bend_next;

    // Decode and compare unit
    logic             accept;
    logic             is_on;
    logic             is_off;
    logic             in_range;
    logic             issue;
    logic [7:0]       cur_note;
    logic [2:0]       cur_stage;
    logic [31:0]      cur_frames;
    logic             cur_idle;
    logic             cur_better;
    logic             note_hit;
    logic             finish;
    logic [IDX_W-1:0] victim;
    logic [6:0]       eval_idx_ext;
    logic [15:0]      hit_bits;

    assign accept   = start && (state_reg == svalloc_pkg::ST_IDLE);
    assign is_on    = (status_byte == svalloc_pkg::MIDI_NOTE_ON) && (data_two != 7'd0);
    assign is_off   = (status_byte == svalloc_pkg::MIDI_NOTE_OFF)
                   || ((status_byte == svalloc_pkg::MIDI_NOTE_ON) && (data_two == 7'd0));
    assign in_range = (7'(voice_index) < 7'(VOICE_COUNT));
    assign issue    = (state_reg == svalloc_pkg::ST_SCAN) && (addr_reg < CNT_END);
    assign rd_addr  = addr_reg[IDX_W-1:0];

    // Evaluate the voice read in the previous cycle
    assign cur_note   = note_rd_vld_reg ? note_rd_reg : svalloc_pkg::NO_NOTE;
    assign cur_stage  = env_rd_vld_reg ? env_rd_reg.stage : 3'd0;
    assign cur_frames = env_rd_vld_reg ? env_rd_reg.frames : 32'd0;
    assign cur_idle   = (cur_stage == 3'd0);
    assign cur_better = (cur_stage > best_stage_reg)
                     || ((cur_stage == best_stage_reg) && (cur_frames > best_frames_reg));
    assign note_hit   = (cur_note == {1'b0, d1_reg});
    assign finish     = eval_vld_reg && ((on_reg && cur_idle) || (eval_idx_reg == LAST_IDX));
    assign victim     = (cur_idle || cur_better) ? eval_idx_reg : best_idx_reg;
    assign eval_idx_ext = 7'(eval_idx_reg);

    // Release mask bit of the evaluated voice (voices 0 to 15 only)
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            hit_bits[i] = eval_vld_reg && note_hit && (eval_idx_ext == 7'(i));
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            svalloc_pkg::ST_IDLE:
            begin
                if (accept && !op && (is_on || is_off))
                begin
                    state_next = svalloc_pkg::ST_SCAN;
                end
            end
            svalloc_pkg::ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = svalloc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = svalloc_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control and result forming
    always_comb
    begin
        note_we          = 1'b0;
        env_we           = 1'b0;
        wr_addr          = IDX_W'(voice_index);
        note_wdata       = svalloc_pkg::NO_NOTE;
        env_wdata.stage  = env_stage;
        env_wdata.frames = env_frames;
        addr_next        = addr_reg;
        eval_vld_next    = 1'b0;
        eval_idx_next    = rd_addr;
        d1_next          = d1_reg;
        d2_next          = d2_reg;
        on_next          = on_reg;
        best_idx_next    = best_idx_reg;
        best_stage_next  = best_stage_reg;
        best_frames_next = best_frames_reg;
        mask_next        = mask_reg;
        done_next        = 1'b0;
        action_next      = svalloc_pkg::ACT_NONE;
        chosen_next      = 4'd0;
        note_out_next    = 7'd0;
        vel_next         = 7'd0;
        rmask_next       = 16'd0;
        bend_next        = 14'd0;

        case (state_reg)
            svalloc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    d1_next          = data_one;
                    d2_next          = data_two;
                    on_next          = is_on;
                    addr_next        = '0;
                    best_idx_next    = '0;
                    best_stage_next  = 3'd0;
                    best_frames_next = 32'd0;
                    mask_next        = 16'd0;
                    if (op)
                    begin
                        // Overwrite stage and frames; free the note on stage 0
                        env_we    = in_range;
                        note_we   = in_range && (env_stage == 3'd0);
                        done_next = 1'b1;
                    end
                    else if (!(is_on || is_off))
                    begin
                        done_next = 1'b1;
                        if (status_byte == svalloc_pkg::MIDI_BEND)
                        begin
                            action_next = svalloc_pkg::ACT_BEND;
                            bend_next   = {data_two, data_one};
                        end
                    end
                end
            end
            svalloc_pkg::ST_SCAN:
            begin
                // Advance the read address one voice a cycle
                if (issue && !finish)
                begin
                    addr_next     = addr_reg + CNT_W'(1);
                    eval_vld_next = 1'b1;
                end
                if (eval_vld_reg)
                begin
                    mask_next = mask_reg | hit_bits;
                    if (cur_better)
                    begin
                        best_idx_next    = eval_idx_reg;
                        best_stage_next  = cur_stage;
                        best_frames_next = cur_frames;
                    end
                end
                if (finish)
                begin
                    done_next     = 1'b1;
                    note_out_next = d1_reg;
                    if (on_reg)
                    begin
                        // Hand the victim the new note
                        note_we          = 1'b1;
                        env_we           = 1'b1;
                        wr_addr          = victim;
                        note_wdata       = {1'b0, d1_reg};
                        env_wdata.stage  = 3'd1;
                        env_wdata.frames = 32'd0;
                        action_next      = svalloc_pkg::ACT_TRIGGER;
                        chosen_next      = 4'(victim);
                        vel_next         = d2_reg;
                    end
                    else
                    begin
                        action_next = svalloc_pkg::ACT_RELEASE;
                        rmask_next  = mask_reg | hit_bits;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Voice table memories with registered read
    always_ff @(posedge clk)
    begin
        if (note_we)
        begin
            note_mem[wr_addr] <= note_wdata;
        end
        if (env_we)
        begin
            env_mem[wr_addr] <= env_wdata;
        end
        note_rd_reg <= note_mem[rd_addr];
        env_rd_reg  <= env_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= svalloc_pkg::ST_IDLE;
            note_vld_reg    <= '0;
            env_vld_reg     <= '0;
            note_rd_vld_reg <= 1'b0;
            env_rd_vld_reg  <= 1'b0;
            addr_reg        <= '0;
            eval_vld_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            note_rd_vld_reg <= note_vld_reg[rd_addr];
            env_rd_vld_reg  <= env_vld_reg[rd_addr];
            if (note_we)
            begin
                note_vld_reg[wr_addr] <= 1'b1;
            end
            if (env_we)
            begin
                env_vld_reg[wr_addr] <= 1'b1;
            end
            addr_reg     <= addr_next;
            eval_vld_reg <= eval_vld_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        eval_idx_reg    <= eval_idx_next;
        d1_reg          <= d1_next;
        d2_reg          <= d2_next;
        on_reg          <= on_next;
        best_idx_reg    <= best_idx_next;
        best_stage_reg  <= best_stage_next;
        best_frames_reg <= best_frames_next;
        mask_reg        <= mask_next;
        action_reg      <= action_next;
        chosen_reg      <= chosen_next;
        note_out_reg    <= note_out_next;
        vel_reg         <= vel_next;
        rmask_reg       <= rmask_next;
        bend_reg        <= bend_next;
    end

    // Drive ports
    assign busy         = (state_reg != svalloc_pkg::ST_IDLE);
    assign done         = done_reg;
    assign action       = action_reg;
    assign chosen_voice = chosen_reg;
    assign note         = note_out_reg;
    assign velocity     = vel_reg;
    assign release_mask = rmask_reg;
    assign bend_value   = bend_reg;

endmodule

`default_nettype wire

[design/svalloc_checker.sv]
// ----------------------------------------------------------------------------
// svalloc_checker
// Port-level checks for the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module svalloc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        op,
    input wire logic [7:0]  status_byte,
    input wire logic [6:0]  data_one,
    input wire logic [6:0]  data_two,
    input wire logic        done,
    input wire logic [1:0]  action,
    input wire logic [3:0]  chosen_voice,
    input wire logic [6:0]  velocity,
    input wire logic [15:0] release_mask,
    input wire logic [13:0] bend_value
);

    // A status report transfer gives an empty result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op) |=> (done && action == svalloc_pkg::ACT_NONE
                                    && release_mask == 16'd0))
        else $error("status report result not empty");

    // A pitch bend transfer gives the raw code in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !op && status_byte == svalloc_pkg::MIDI_BEND)
        |=> (done && action == svalloc_pkg::ACT_BEND
             && bend_value == $past({data_two, data_one})))
        else $error("pitch bend result wrong");

    // A note on transfer starts a voice scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !op && status_byte == svalloc_pkg::MIDI_NOTE_ON
         && data_two != 7'd0) |=> (busy && !done))
        else $error("note on did not start a scan");

    // Only a trigger carries a velocity or a voice
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && action != svalloc_pkg::ACT_TRIGGER)
        |-> (velocity == 7'd0 && chosen_voice == 4'd0))
        else $error("trigger fields set on a non-trigger result");

endmodule

bind synth_voice_allocator_top svalloc_checker u_svalloc_checker (.*);

`default_nettype wire

[tb/tb_synth_voice_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_synth_voice_allocator_top
// Self-checking testbench for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
// A driver presents queued MIDI messages and voice status reports on the
// start/busy handshake, with random idle cycles. At each transfer a shadow of
// the voice table predicts the single result the item must produce. A monitor
// compares every done strobe field by field against the oldest prediction.
// The stimulus opens with a short directed list: bend extremes, unknown
// status bytes, note off by velocity zero, and frees and holds through status
// reports. A random mix follows: note-on bursts that force voice stealing,
// stage and frame ties, and note offs of recently played notes, plus noise.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_synth_voice_allocator_top;

    localparam int VOICE_TOTAL  = svalloc_pkg::VOICE_COUNT_DEF;
    localparam int ITEM_TARGET  = 1250;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = VOICE_TOTAL + 8;
    localparam int REPORT_LIMIT = 10;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 800;

    localparam logic       OP_MIDI     = 1'b0;
    localparam logic       OP_REPORT   = 1'b1;
    localparam logic [2:0] STAGE_IDLE  = 3'd0;
    localparam logic [2:0] STAGE_FIRST = 3'd1;
    localparam logic [2:0] STAGE_LAST  = 3'd7;

    typedef struct packed {
        logic        op;
        logic [7:0]  status_byte;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [3:0]  voice_index;
        logic [2:0]  env_stage;
        logic [31:0] env_frames;
    } midi_event_t;

    typedef struct packed {
        svalloc_pkg::action_t action;
        logic [3:0]           chosen_voice;
        logic [6:0]           note;
        logic [6:0]           velocity;
        logic [15:0]          release_mask;
        logic [13:0]          bend_value;
    } voice_action_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        op = 1'b0;
    logic [7:0]  status_byte = '0;
    logic [6:0]  data_one = '0;
    logic [6:0]  data_two = '0;
    logic [3:0]  voice_index = '0;
    logic [2:0]  env_stage = '0;
    logic [31:0] env_frames = '0;
    logic        busy;
    logic        done;
    logic [1:0]  action;
    logic [3:0]  chosen_voice;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] release_mask;
    logic [13:0] bend_value;

    // Shadow voice table
    logic [7:0]  voice_note   [VOICE_TOTAL];
    logic [2:0]  voice_stage  [VOICE_TOTAL];
    logic [31:0] voice_frames [VOICE_TOTAL];

    midi_event_t   pending_events[$];
    voice_action_t expected_actions[$];
    midi_event_t   held_event;
    int            transfer_count = 0;
    int            mismatch_count = 0;
    int            stall_cycles = 0;

    synth_voice_allocator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .status_byte  (status_byte),
        .data_one     (data_one),
        .data_two     (data_two),
        .voice_index  (voice_index),
        .env_stage    (env_stage),
        .env_frames   (env_frames),
        .done         (done),
        .action       (action),
        .chosen_voice (chosen_voice),
        .note         (note),
        .velocity     (velocity),
        .release_mask (release_mask),
        .bend_value   (bend_value)
    );

    always #10 clk = ~clk;

    // Update the shadow table with one transfer and queue its expected action
    task automatic apply_event(input midi_event_t ev);
        voice_action_t res;
        int            victim;
        int            i;
        res = '0;
        if (ev.op == OP_REPORT)
        begin
            if (ev.voice_index < VOICE_TOTAL)
            begin
                voice_stage[ev.voice_index]  = ev.env_stage;
                voice_frames[ev.voice_index] = ev.env_frames;
                if (ev.env_stage == STAGE_IDLE)
                    voice_note[ev.voice_index] = svalloc_pkg::NO_NOTE;
            end
        end
        else if (ev.status_byte == svalloc_pkg::MIDI_NOTE_ON && ev.data_two != 7'd0)
        begin
            // Take the first idle voice, else steal highest stage, then most frames
            victim = -1;
            for (i = 0; i < VOICE_TOTAL && victim < 0; i++)
                if (voice_stage[i] == STAGE_IDLE)
                    victim = i;
            if (victim < 0)
            begin
                victim = 0;
                for (i = 1; i < VOICE_TOTAL; i++)
                    if (voice_stage[i] > voice_stage[victim] ||
                        (voice_stage[i] == voice_stage[victim] &&
                         voice_frames[i] > voice_frames[victim]))
                        victim = i;
            end
            voice_note[victim]   = {1'b0, ev.data_one};
            voice_stage[victim]  = STAGE_FIRST;
            voice_frames[victim] = '0;
            res.action       = svalloc_pkg::ACT_TRIGGER;
            res.chosen_voice = 4'(victim);
            res.note         = ev.data_one;
            res.velocity     = ev.data_two;
        end
        else if (ev.status_byte == svalloc_pkg::MIDI_NOTE_OFF ||
                 ev.status_byte == svalloc_pkg::MIDI_NOTE_ON)
        begin
            for (i = 0; i < VOICE_TOTAL && i < 16; i++)
                if (voice_note[i] == {1'b0, ev.data_one})
                    res.release_mask[i] = 1'b1;
            res.action = svalloc_pkg::ACT_RELEASE;
            res.note   = ev.data_one;
        end
        else if (ev.status_byte == svalloc_pkg::MIDI_BEND)
        begin
            res.action     = svalloc_pkg::ACT_BEND;
            res.bend_value = {ev.data_two, ev.data_one};
        end
        expected_actions.push_back(res);
    endtask

    // MIDI message with random filler in the report fields
    function automatic midi_event_t make_midi(input logic [7:0] code,
                                              input logic [6:0] d1,
                                              input logic [6:0] d2);
        midi_event_t ev;
        ev.op          = OP_MIDI;
        ev.status_byte = code;
        ev.data_one    = d1;
        ev.data_two    = d2;
        ev.voice_index = 4'($urandom);
        ev.env_stage   = 3'($urandom);
        ev.env_frames  = $urandom;
        return ev;
    endfunction

    // Status report with random filler in the MIDI fields
    function automatic midi_event_t make_report(input logic [3:0]  idx,
                                                input logic [2:0]  stage,
                                                input logic [31:0] frames);
        midi_event_t ev;
        ev.op          = OP_REPORT;
        ev.status_byte = 8'($urandom);
        ev.data_one    = 7'($urandom);
        ev.data_two    = 7'($urandom);
        ev.voice_index = idx;
        ev.env_stage   = stage;
        ev.env_frames  = frames;
        return ev;
    endfunction

    // Frame counts biased toward extremes and small values to create ties
    function automatic logic [31:0] pick_frames();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    // Drive items on the handshake; hold each until busy is low
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                apply_event(held_event);
                transfer_count++;
            end
            if (!start || !busy)
            begin
                if (pending_events.size() != 0 &&
                    !((transfer_count < CALM_FIRST || transfer_count >= CALM_LAST) &&
                      $urandom_range(99) < 16))
                begin
                    held_event   = pending_events.pop_front();
                    op          <= held_event.op;
                    status_byte <= held_event.status_byte;
                    data_one    <= held_event.data_one;
                    data_two    <= held_event.data_two;
                    voice_index <= held_event.voice_index;
                    env_stage   <= held_event.env_stage;
                    env_frames  <= held_event.env_frames;
                    start       <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Compare each result strobe with the oldest expected action
    always @(posedge clk)
    begin
        voice_action_t exp_act;
        if (rst_n && done)
        begin
            if (expected_actions.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: action=%0d voice=%0d note=%0d", action,
                             chosen_voice, note);
            end
            else
            begin
                exp_act = expected_actions.pop_front();
                if (action != exp_act.action || chosen_voice != exp_act.chosen_voice ||
                    note != exp_act.note || velocity != exp_act.velocity ||
                    release_mask != exp_act.release_mask ||
                    bend_value != exp_act.bend_value)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display({"mismatch exp: act=%0d voice=%0d note=%0d vel=%0d",
                                  " mask=%h bend=%h"},
                                 exp_act.action, exp_act.chosen_voice, exp_act.note,
                                 exp_act.velocity, exp_act.release_mask, exp_act.bend_value);
                        $display({"         got: act=%0d voice=%0d note=%0d vel=%0d",
                                  " mask=%h bend=%h"},
                                 action, chosen_voice, note, velocity, release_mask,
                                 bend_value);
                    end
                end
            end
        end
    end

    // Abort when neither a transfer nor a result shows up for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout waiting for transfer or result");
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Build the stimulus, run reset, then drain and report
    initial
    begin
        logic [6:0] note_pool[8];
        int         r;
        int         n;
        int         k;
        for (k = 0; k < VOICE_TOTAL; k++)
        begin
            voice_note[k]   = svalloc_pkg::NO_NOTE;
            voice_stage[k]  = STAGE_IDLE;
            voice_frames[k] = '0;
        end
        for (k = 0; k < 8; k++)
            note_pool[k] = 7'($urandom);

        // Directed part
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_OFF, 7'd0, 7'd0));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_BEND, 7'd0, 7'd0));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_BEND, 7'd127, 7'd127));
        pending_events.push_back(make_midi(8'h00, 7'd127, 7'd127));
        pending_events.push_back(make_midi(8'hFF, 7'd0, 7'd1));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_ON + 8'd1, 7'd60, 7'd100));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_ON, 7'd0, 7'd1));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_ON, 7'd127, 7'd127));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_ON, 7'd0, 7'd64));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_ON, 7'd0, 7'd0));
        pending_events.push_back(make_report(4'd0, STAGE_IDLE, '1));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_OFF, 7'd0, 7'd0));
        pending_events.push_back(make_report(4'd1, STAGE_LAST, '1));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_OFF, 7'd127, 7'd127));
        pending_events.push_back(make_report(4'd15, 3'd3, '0));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_ON, 7'd5, 7'd127));
        pending_events.push_back(make_report(4'd2, STAGE_IDLE, '0));
        pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_OFF, 7'd0, 7'd0));

        // Random part
        while (pending_events.size() < ITEM_TARGET)
        begin
            r = $urandom_range(99);
            if (r < 30)
            begin
                pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_ON,
                    ($urandom_range(99) < 60) ? note_pool[$urandom_range(7)] : 7'($urandom),
                    7'($urandom_range(127, 1))));
            end
            else if (r < 45)
            begin
                if ($urandom_range(1) == 0)
                    pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_OFF,
                        note_pool[$urandom_range(7)], 7'($urandom)));
                else
                    pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_ON,
                        note_pool[$urandom_range(7)], 7'd0));
            end
            else if (r < 70)
            begin
                pending_events.push_back(make_report(4'($urandom),
                    ($urandom_range(99) < 20) ? STAGE_IDLE : 3'($urandom_range(7, 1)),
                    pick_frames()));
            end
            else if (r < 78)
            begin
                pending_events.push_back(make_midi(svalloc_pkg::MIDI_BEND, 7'($urandom),
                                                   7'($urandom)));
            end
            else if (r < 85)
            begin
                // Fill every voice so later note ons must steal
                n = $urandom_range(VOICE_TOTAL + 4, VOICE_TOTAL);
                for (k = 0; k < n; k++)
                    pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_ON,
                        note_pool[$urandom_range(7)], 7'($urandom_range(127, 1))));
                note_pool[$urandom_range(7)] = 7'($urandom);
            end
            else if (r < 92)
            begin
                // Tie several voices on stage and frames, then steal
                n = $urandom_range(6, 2);
                for (k = 0; k < n; k++)
                    pending_events.push_back(make_report(4'($urandom),
                        ($urandom_range(1) == 0) ? STAGE_LAST : 3'($urandom_range(7, 5)),
                        ($urandom_range(1) == 0) ? 32'($urandom_range(1)) : '1));
                pending_events.push_back(make_midi(svalloc_pkg::MIDI_NOTE_ON,
                    note_pool[$urandom_range(7)], 7'($urandom_range(127, 1))));
            end
            else
            begin
                pending_events.push_back({1'($urandom), 8'($urandom), 7'($urandom),
                                          7'($urandom), 4'($urandom), 3'($urandom),
                                          32'($urandom)});
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_events.size() != 0 || start || expected_actions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_actions.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
